// ----- sv/psba_pkg.sv -----
// Package for the page slot bitmap allocator.
// It holds the sizes, operation and status codes and the bit search helper.
// It depends on nothing else.
package psba_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int WORD_BITS = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;
    localparam int NUM_WORDS = MAX_SLOTS / WORD_BITS;
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int PTR_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int CW        = (CNT_W > 12) ? CNT_W : 12;

    localparam int OP_W     = 3;
    localparam int SLOT_W   = 11;
    localparam int CAP_W    = 11;
    localparam int STRIDE_W = 14;
    localparam int FIRST_W  = 13;
    localparam int CFG_W    = 14;
    localparam int STAT_W   = 3;
    localparam int SIDX_W   = 10;
    localparam int OFF_W    = 24;
    localparam int USED_W   = 11;

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_GET    = 3'd2;
    localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EOS     = 3'd4;

    localparam logic [1:0] REG_CAPACITY = 2'd0;
    localparam logic [1:0] REG_STRIDE   = 2'd1;
    localparam logic [1:0] REG_FIRST    = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_ACCESS = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    typedef struct packed {
        logic             found;
        logic [BIT_W-1:0] pos;
    } hit_t;

    // Lowest set bit of one bitmap word.
    function automatic hit_t lowest_set(input logic [WORD_BITS-1:0] v);
        hit_t h;
        h.found = 1'b0;
        h.pos   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                h.found = 1'b1;
                h.pos   = BIT_W'(i);
            end
        end
        return h;
    endfunction

endpackage

// ----- sv/page_slot_bitmap_allocator.sv -----
// Top level of the page slot bitmap allocator: bitmap, sequencer and result register.
// It depends on psba_pkg.
//
// Usage: one input channel (in_valid, in_stall, opcode, slot) carries operations,
// one output channel (out_valid, out_stall and the result fields) returns exactly
// one result item per input item. An item moves at a clock edge where valid is
// high and stall is low. Registers are written through cfg_we, cfg_index and
// cfg_data only while the block is idle; the user is bound to this and the block
// does not enforce it. Indexes beyond the list are ignored.
// Get and delete pass from acceptance through the access step to the final step;
// clear and rejected items go straight to the final step. Insert and next scan the
// bitmap one word of WORD_BITS bits per cycle until a hit or the last word. One
// item is in work at a time; in_stall is high from acceptance until the result is
// loaded into the output register. The output register lets a new item be accepted
// while the last result waits. When the receiver stalls, the result holds and a
// finished item waits in the final step until the output register is free.
// Reset clears the whole bitmap and the used count at once and loads the
// registers with capacity 0, stride 8 and first offset 0.
module page_slot_bitmap_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [psba_pkg::OP_W-1:0]    opcode,
    input  logic signed [psba_pkg::SLOT_W-1:0] slot,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [psba_pkg::STAT_W-1:0]  status,
    output logic [psba_pkg::SIDX_W-1:0]  slot_index,
    output logic [psba_pkg::OFF_W-1:0]   byte_offset,
    output logic                         page_empty,
    output logic [psba_pkg::USED_W-1:0]  used_slots,
    input  logic                         cfg_we,
    input  logic [1:0]                   cfg_index,
    input  logic [psba_pkg::CFG_W-1:0]   cfg_data
);
    import psba_pkg::*;

    // Occupancy bitmap, one word per entry, read at the word the sequencer selects.
    logic [WORD_BITS-1:0] occ_reg [NUM_WORDS];

    logic [CAP_W-1:0]    cap_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [FIRST_W-1:0]  first_reg;

    state_t state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [IDX_W-1:0]     addr_reg, addr_next;
    logic [PTR_W-1:0]     ptr_reg, ptr_next;
    logic [WORD_BITS-1:0] lo_mask_reg, lo_mask_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [STAT_W-1:0]    res_status_reg, res_status_next;
    logic                 have_idx_reg, have_idx_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 empty_reg, empty_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]    status_reg;
    logic [SIDX_W-1:0]    slot_index_reg;
    logic [OFF_W-1:0]     byte_offset_reg;
    logic                 page_empty_reg;
    logic [USED_W-1:0]    used_slots_reg;

    // Bitmap write controls.
    logic                 occ_we;
    logic [PTR_W-1:0]     occ_waddr;
    logic [BIT_W-1:0]     occ_wbit;
    logic                 occ_wval;
    logic                 occ_clear;

    logic [CW-1:0]        cap_eff;
    logic [CW-BIT_W-1:0]  cap_word;
    logic [BIT_W-1:0]     cap_lo;
    logic [CW-BIT_W-1:0]  ptr_ext;
    logic [WORD_BITS-1:0] cur_word;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] cand;
    hit_t                 hit;
    logic                 last_word;

    logic                 accept;
    logic                 load_out;
    logic [CW-1:0]        slot_u;
    logic [CW-1:0]        start;
    logic                 slot_neg;
    logic                 slot_minus1;
    logic                 cur_bit;
    logic [CW-1:0]        idx_ext;
    logic [OFF_W-1:0]     offset_calc;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Capacity is limited to the size of the bitmap.
    assign cap_eff  = (CW'(cap_reg) > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(cap_reg);
    assign cap_word = cap_eff[CW-1:BIT_W];
    assign cap_lo   = cap_eff[BIT_W-1:0];

    assign slot_neg    = slot[SLOT_W-1];
    assign slot_minus1 = (slot == '1);
    assign slot_u      = CW'(slot[SLOT_W-2:0]);
    assign start       = slot_minus1 ? '0 : (slot_u + CW'(1));

    // Word scan: mask the word to the slots below capacity and, in the first
    // word of a next scan, to the slots after the given one.
    assign ptr_ext  = (CW - BIT_W)'(ptr_reg);
    assign cur_word = occ_reg[ptr_reg];
    always_comb
    begin
        if (ptr_ext < cap_word)
        begin
            hi_mask = '1;
        end
        else if (ptr_ext == cap_word)
        begin
            hi_mask = ~({WORD_BITS{1'b1}} << cap_lo);
        end
        else
        begin
            hi_mask = '0;
        end
    end
    assign cand      = ((op_reg == OP_INSERT) ? ~cur_word : cur_word) & lo_mask_reg & hi_mask;
    assign hit       = lowest_set(cand);
    assign last_word = (ptr_reg == PTR_W'(NUM_WORDS - 1)) || (ptr_ext >= cap_word);

    assign cur_bit = occ_reg[addr_reg[IDX_W-1:BIT_W]][addr_reg[BIT_W-1:0]];

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        ptr_next        = ptr_reg;
        lo_mask_next    = lo_mask_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        have_idx_next   = have_idx_reg;
        idx_next        = idx_reg;
        empty_next      = empty_reg;
        occ_we          = 1'b0;
        occ_waddr       = ptr_reg;
        occ_wbit        = hit.pos;
        occ_wval        = 1'b1;
        occ_clear       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = opcode;
                    have_idx_next   = 1'b0;
                    idx_next        = '0;
                    empty_next      = 1'b0;
                    res_status_next = STAT_INVALID;
                    state_next      = ST_DONE;
                    case (opcode)
                        OP_INSERT:
                        begin
                            res_status_next = STAT_FULL;
                            if (CW'(used_reg) < cap_eff)
                            begin
                                ptr_next     = '0;
                                lo_mask_next = '1;
                                state_next   = ST_SCAN;
                            end
                        end
                        OP_DELETE, OP_GET:
                        begin
                            if (!slot_neg && (slot_u < cap_eff))
                            begin
                                addr_next  = slot_u[IDX_W-1:0];
                                state_next = ST_ACCESS;
                            end
                        end
                        OP_NEXT:
                        begin
                            if (slot_neg && !slot_minus1)
                            begin
                                res_status_next = STAT_INVALID;
                            end
                            else if (start >= cap_eff)
                            begin
                                res_status_next = STAT_EOS;
                            end
                            else
                            begin
                                ptr_next     = start[BIT_W+PTR_W-1:BIT_W];
                                lo_mask_next = {WORD_BITS{1'b1}} << start[BIT_W-1:0];
                                state_next   = ST_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            occ_clear       = 1'b1;
                            used_next       = '0;
                            res_status_next = STAT_OK;
                        end
                        default:
                        begin
                            res_status_next = STAT_INVALID;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit.found)
                begin
                    idx_next        = {ptr_reg, hit.pos};
                    have_idx_next   = 1'b1;
                    res_status_next = STAT_OK;
                    state_next      = ST_DONE;
                    if (op_reg == OP_INSERT)
                    begin
                        occ_we    = 1'b1;
                        used_next = used_reg + CNT_W'(1);
                    end
                end
                else if (last_word)
                begin
                    res_status_next = (op_reg == OP_INSERT) ? STAT_FULL : STAT_EOS;
                    state_next      = ST_DONE;
                end
                else
                begin
                    ptr_next     = ptr_reg + PTR_W'(1);
                    lo_mask_next = '1;
                end
            end
            ST_ACCESS:
            begin
                idx_next      = addr_reg;
                have_idx_next = 1'b1;
                state_next    = ST_DONE;
                if (!cur_bit)
                begin
                    res_status_next = STAT_EMPTY;
                end
                else
                begin
                    res_status_next = STAT_OK;
                    if (op_reg == OP_DELETE)
                    begin
                        occ_we    = 1'b1;
                        occ_waddr = addr_reg[IDX_W-1:BIT_W];
                        occ_wbit  = addr_reg[BIT_W-1:0];
                        occ_wval  = 1'b0;
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - CNT_W'(1);
                        end
                        empty_next = (used_reg <= CNT_W'(1));
                    end
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The byte offset is formed in the final step from the registered slot.
    assign idx_ext     = CW'(idx_reg);
    assign offset_calc = OFF_W'(first_reg) + (OFF_W'(idx_ext) * OFF_W'(stride_reg));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                occ_reg[w] <= '0;
            end
        end
        else if (occ_clear)
        begin
            for (int w = 0; w < NUM_WORDS; w++)
            begin
                occ_reg[w] <= '0;
            end
        end
        else if (occ_we)
        begin
            occ_reg[occ_waddr][occ_wbit] <= occ_wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg    <= '0;
            stride_reg <= STRIDE_W'(8);
            first_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAPACITY: cap_reg    <= cfg_data[CAP_W-1:0];
                REG_STRIDE:   stride_reg <= cfg_data[STRIDE_W-1:0];
                REG_FIRST:    first_reg  <= cfg_data[FIRST_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        addr_reg       <= addr_next;
        ptr_reg        <= ptr_next;
        lo_mask_reg    <= lo_mask_next;
        res_status_reg <= res_status_next;
        have_idx_reg   <= have_idx_next;
        idx_reg        <= idx_next;
        empty_reg      <= empty_next;
        if (load_out)
        begin
            status_reg      <= res_status_reg;
            slot_index_reg  <= have_idx_reg ? idx_ext[SIDX_W-1:0] : '0;
            byte_offset_reg <= have_idx_reg ? offset_calc : '0;
            page_empty_reg  <= empty_reg;
            used_slots_reg  <= USED_W'(used_reg);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign slot_index  = slot_index_reg;
    assign byte_offset = byte_offset_reg;
    assign page_empty  = page_empty_reg;
    // The count is captured with the rest of the result, so it holds while the
    // receiver stalls even when the next item has already changed the count.
    assign used_slots  = used_slots_reg;

endmodule

// ----- test/page_slot_bitmap_allocator_tb.sv -----
// Testbench for page_slot_bitmap_allocator: directed and random slot operations, each
// result checked field by field against a predictor of the occupancy bitmap and count.
// It depends on psba_pkg and the page_slot_bitmap_allocator RTL, and on nothing else.
module page_slot_bitmap_allocator_tb;
    import psba_pkg::*;

    // Receiver hold-off used to back the block up, and the watchdog limit on cycles
    // in which neither channel moves an item. The limit is several times the hold-off.
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 2000;
    // Settle window at the end, after the last expected result.
    localparam int SETTLE_CYCLES = 24;
    localparam int REPORT_LIMIT  = 40;

    // Register index that maps to nothing, and the range of undefined opcodes.
    localparam logic [1:0]      REG_SPARE    = 2'd3;
    localparam logic [OP_W-1:0] OP_BAD_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_BAD_LAST  = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SIDX_W-1:0] slot_index;
        logic [OFF_W-1:0]  byte_offset;
        logic              page_empty;
        logic [USED_W-1:0] used_slots;
    } slot_result_t;

    // Tracks the page the way the block should: bitmap, used count and the three
    // registers. Each accepted item is turned into the result it must produce, and
    // results coming out of the block are matched against those in order.
    class slot_map_checker;
        bit [MAX_SLOTS-1:0] taken;
        int                 in_use;
        int                 cap_reg;
        int                 stride_reg;
        int                 base_reg;
        slot_result_t       awaited[$];
        int                 errors;

        function new();
            taken      = '0;
            in_use     = 0;
            cap_reg    = 0;
            stride_reg = 8;
            base_reg   = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_CAPACITY: cap_reg    = int'(data[CAP_W-1:0]);
                REG_STRIDE:   stride_reg = int'(data[STRIDE_W-1:0]);
                REG_FIRST:    base_reg   = int'(data[FIRST_W-1:0]);
                default:      ;
            endcase
        endfunction

        // Capacity as the block uses it: the register clipped to the bitmap size.
        function int usable();
            return (cap_reg > MAX_SLOTS) ? MAX_SLOTS : cap_reg;
        endfunction

        // Some occupied slot, searched upward from a random point, so that deletes
        // and gets often hit live records. Falls back to a low slot on an empty page.
        function int any_taken_slot();
            int start;
            int k;
            start = $urandom_range(0, MAX_SLOTS - 1);
            for (k = 0; k < MAX_SLOTS; k++)
            begin
                if (taken[(start + k) % MAX_SLOTS])
                    return (start + k) % MAX_SLOTS;
            end
            return $urandom_range(0, 3);
        endfunction

        function void accept_op(logic [OP_W-1:0] op, logic signed [SLOT_W-1:0] s);
            slot_result_t r;
            int           cap;
            int           target;
            int           idx;
            int           i;
            bit           hit;
            longint       off;
            cap    = usable();
            target = int'(s);
            idx    = 0;
            hit    = 1'b0;
            r      = '0;
            r.status = STAT_INVALID;
            case (op)
                OP_INSERT:
                begin
                    // Lowest free slot below capacity; the count check comes first, so
                    // records left above a lowered capacity still make the page full.
                    r.status = STAT_FULL;
                    if (in_use < cap)
                    begin
                        for (i = 0; i < cap && !hit; i++)
                        begin
                            if (!taken[i])
                            begin
                                taken[i] = 1'b1;
                                in_use++;
                                idx      = i;
                                hit      = 1'b1;
                                r.status = STAT_OK;
                            end
                        end
                    end
                end
                OP_DELETE, OP_GET:
                begin
                    if (target >= 0 && target < cap)
                    begin
                        idx = target;
                        hit = 1'b1;
                        if (!taken[target])
                            r.status = STAT_EMPTY;
                        else
                        begin
                            r.status = STAT_OK;
                            if (op == OP_DELETE)
                            begin
                                taken[target] = 1'b0;
                                if (in_use > 0)
                                    in_use--;
                                r.page_empty = (in_use == 0);
                            end
                        end
                    end
                end
                OP_NEXT:
                begin
                    // Minus one starts the scan; anything lower is rejected.
                    if (target >= -1)
                    begin
                        r.status = STAT_EOS;
                        for (i = target + 1; i < cap && !hit; i++)
                        begin
                            if (taken[i])
                            begin
                                idx      = i;
                                hit      = 1'b1;
                                r.status = STAT_OK;
                            end
                        end
                    end
                end
                OP_CLEAR:
                begin
                    taken    = '0;
                    in_use   = 0;
                    r.status = STAT_OK;
                end
                default: r.status = STAT_INVALID;
            endcase
            if (hit)
            begin
                off          = longint'(base_reg) + longint'(idx) * longint'(stride_reg);
                r.slot_index = idx[SIDX_W-1:0];
                r.byte_offset = off[OFF_W-1:0];
            end
            r.used_slots = in_use[USED_W-1:0];
            awaited.push_back(r);
        endfunction

        function void field_ok(string name, int want, int got);
            if (want != got)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_result(slot_result_t got);
            slot_result_t want;
            if (awaited.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("%0t: result with none pending, expected none, actual status %0d",
                             $time, got.status);
            end
            else
            begin
                want = awaited.pop_front();
                field_ok("status", want.status, got.status);
                field_ok("slot_index", want.slot_index, got.slot_index);
                field_ok("byte_offset", want.byte_offset, got.byte_offset);
                field_ok("page_empty", want.page_empty, got.page_empty);
                field_ok("used_slots", want.used_slots, got.used_slots);
            end
        endfunction
    endclass

    // Every input of the block starts at a known value.
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    logic [OP_W-1:0]    opcode    = '0;
    logic signed [SLOT_W-1:0] slot = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [STAT_W-1:0]  status;
    logic [SIDX_W-1:0]  slot_index;
    logic [OFF_W-1:0]   byte_offset;
    logic               page_empty;
    logic [USED_W-1:0]  used_slots;
    logic               cfg_we    = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data  = '0;

    slot_map_checker tracker;
    int              burst_left;
    int              idle_cycles = 0;
    bit              hold_req    = 1'b0;

    page_slot_bitmap_allocator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .slot       (slot),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot_index (slot_index),
        .byte_offset(byte_offset),
        .page_empty (page_empty),
        .used_slots (used_slots),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #2 clk = ~clk;

    // Watchdog: the run is declared hung once the stretch in which no item moves on
    // either channel reaches IDLE_LIMIT. The long receiver hold-off is well inside it.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver. Results are sampled at the clock edge with the values from before the
    // edge. The stall pattern changes mode at random: some stretches never stall,
    // others stall lightly or heavily. When the stimulus asks for it, the receiver
    // holds off without a break so that the block backs up and stalls its input.
    initial
    begin
        int           hold_left;
        int           mode_left;
        int           stall_pct;
        slot_result_t got;
        hold_left = 0;
        mode_left = 0;
        stall_pct = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.status      = status;
                got.slot_index  = slot_index;
                got.byte_offset = byte_offset;
                got.page_empty  = page_empty;
                got.used_slots  = used_slots;
                tracker.check_result(got);
            end
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(20, 200);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Offers one item and returns at the edge where it is taken. The sender works in
    // bursts: while a burst lasts, valid stays high into the next item; at its end valid
    // drops for a random gap and a new burst length is drawn.
    task automatic send_item(logic [OP_W-1:0] op, int s);
        in_valid <= 1'b1;
        opcode   <= op;
        slot     <= SLOT_W'(s);
        do
            @(posedge clk);
        while (in_stall);
        tracker.accept_op(op, SLOT_W'(s));
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Stops offering and waits until every pending result has come back. Since each
    // item gives exactly one result, the block is idle once the count reaches zero.
    task automatic drain();
        if (in_valid)
            in_valid <= 1'b0;
        while (tracker.awaited.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Register writes leave the write enable high; configure drops it after the last.
    task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.write_reg(idx, data);
    endtask

    task automatic configure(int cap, int stride, int first);
        write_reg(REG_CAPACITY, CFG_W'(cap));
        write_reg(REG_STRIDE, CFG_W'(stride));
        write_reg(REG_FIRST, CFG_W'(first));
        cfg_we <= 1'b0;
    endtask

    // One random phase under one register setting. Most items are inserts, deletes,
    // gets and scans on slots near the live range, so the page fills, empties and is
    // scanned; the rest are clears, undefined opcodes and slots drawn from all 11 bits.
    // The page is not cleared between phases, so a lowered capacity leaves records
    // stranded above it.
    task automatic run_phase(int cap, int stride, int first, int count, bit pressure);
        int              k;
        int              pick;
        int              s;
        int              hi;
        logic [OP_W-1:0] op;
        configure(cap, stride, first);
        if (pressure)
            hold_req = 1'b1;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 38)
                op = OP_INSERT;
            else if (pick < 63)
                op = OP_DELETE;
            else if (pick < 76)
                op = OP_GET;
            else if (pick < 92)
                op = OP_NEXT;
            else if (pick < 95)
                op = OP_CLEAR;
            else
                op = OP_W'($urandom_range(OP_BAD_FIRST, OP_BAD_LAST));
            hi = tracker.usable();
            if (hi > 1023)
                hi = 1023;
            pick = $urandom_range(0, 9);
            if (pick == 0)
                s = $urandom_range(0, 2047);
            else if (pick == 1)
                s = -1;
            else if (pick <= 5)
                s = tracker.any_taken_slot();
            else
                s = int'($urandom_range(0, hi + 1)) - 1;
            send_item(op, s);
        end
        drain();
    endtask

    initial
    begin
        tracker    = new();
        burst_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state: capacity zero, so inserts report a full page, scans end at once
        // and every slot is out of range.
        send_item(OP_INSERT, 0);
        send_item(OP_NEXT, -1);
        send_item(OP_GET, 0);
        drain();

        // A write to the unused index must change nothing. Then a four-slot page with
        // the largest stride and first offset.
        write_reg(REG_SPARE, CFG_W'($urandom));
        configure(4, 16383, 8191);
        repeat (4) send_item(OP_INSERT, 0);
        send_item(OP_INSERT, 0);        // page full
        send_item(OP_GET, 2);
        send_item(OP_DELETE, 1);
        send_item(OP_GET, 1);           // freed slot reads as empty
        send_item(OP_DELETE, 1);        // delete of an empty slot
        send_item(OP_NEXT, -1);         // scan from the start
        send_item(OP_NEXT, 0);          // skips the hole at slot 1
        send_item(OP_NEXT, 3);          // at the last slot: end of scan
        send_item(OP_NEXT, -2);         // below minus one is invalid
        send_item(OP_NEXT, 1023);
        send_item(OP_GET, -1);          // negative slot
        send_item(OP_GET, 4);           // slot at capacity
        send_item(OP_DELETE, -1024);
        send_item(OP_BAD_FIRST, 2);
        send_item(OP_BAD_LAST, 0);
        send_item(OP_DELETE, 0);
        send_item(OP_DELETE, 2);
        send_item(OP_DELETE, 3);        // last record gone: page empty flag
        send_item(OP_CLEAR, 0);
        drain();

        // Random phases. Extremes: capacity zero, one, the bitmap size and the largest
        // register value; stride zero and maximum; first offset zero and maximum.
        run_phase(16, 8, 0, 90, 1'b0);
        run_phase(1024, 16383, 8191, 70, 1'b0);
        run_phase(5, 0, 8191, 80, 1'b0);
        run_phase(2047, 8, 100, 60, 1'b0);
        run_phase(65, 24, 4000, 90, 1'b1);
        run_phase(3, 8192, 0, 80, 1'b0);
        run_phase(1, $urandom_range(0, 16383), $urandom_range(0, 8191), 50, 1'b0);
        run_phase(0, 8, 0, 30, 1'b0);
        run_phase(130, $urandom_range(1, 1023) * 8, $urandom_range(0, 8191), 120, 1'b0);

        // Any stray result after the last expected one is caught in this window.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
